// ===== hdl/multilevel_bucket_priority_queue_defines.svh =====
// Assertion macros for the multilevel bucket priority queue.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef MULTILEVEL_BUCKET_PRIORITY_QUEUE_DEFINES_SVH
`define MULTILEVEL_BUCKET_PRIORITY_QUEUE_DEFINES_SVH

// check a condition at every clock edge out of reset
`define MLBPQ_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define MLBPQ_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/mlbpq_pkg.sv =====
// Package of the multilevel bucket priority queue: field widths, default
// parameters, operation codes, controller states and the result struct.
// No dependencies.
package mlbpq_pkg;

  localparam int unsigned LEVELS_DEF     = 2;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned DIGIT_BITS_DEF = 8;
  localparam int unsigned MAX_ITEMS_DEF  = 1024;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_IN_W = 16;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned TOTAL_W  = 11;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_LVL,
    ST_BRD,
    ST_BCHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_TAKE,
    ST_B1_RD,
    ST_B1_WR,
    ST_B2_RD,
    ST_B2_WR,
    ST_RNEXT,
    ST_RRD,
    ST_RCHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]    result_id;
    logic               queue_empty;
    logic               bad_request;
    logic [TOTAL_W-1:0] item_total;
  } res_t;

endpackage

// ===== hdl/mlbpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port,
// read data registered. No dependencies.
module mlbpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mlbpq_core.sv =====
// Controller of the multilevel bucket priority queue: sequences clearing,
// insert, decrease and extract over the item and bucket memories.
// Depends on mlbpq_pkg and the assertion macro header.
`include "multilevel_bucket_priority_queue_defines.svh"

module mlbpq_core
  import mlbpq_pkg::*;
#(
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF,
  parameter int unsigned MAX_ITEMS  = MAX_ITEMS_DEF,
  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS),
  localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int unsigned REC_W  = 1 + KEY_BITS + LVL_W + DIGIT_BITS,
  localparam int unsigned BA_W   = LVL_W + DIGIT_BITS,
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic [ID_W-1:0]     item_id_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output res_t                res_o,
  output logic                ir_we_o,
  output logic [IDX_W-1:0]    ir_waddr_o,
  output logic [REC_W-1:0]    ir_wdata_o,
  output logic [IDX_W-1:0]    ir_raddr_o,
  input  logic [REC_W-1:0]    ir_rdata_i,
  output logic                br_we_o,
  output logic [BA_W-1:0]     br_waddr_o,
  output logic [CNT_W-1:0]    br_wdata_o,
  output logic [BA_W-1:0]     br_raddr_o,
  input  logic [CNT_W-1:0]    br_rdata_i
);

  localparam int unsigned BDEPTH = 1 << BA_W;
  localparam int unsigned CLR_N  = (MAX_ITEMS > BDEPTH) ? MAX_ITEMS : BDEPTH;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam int unsigned SUM_W  = CNT_W + 2;

  function automatic logic [LVL_W-1:0] lvl_of(input logic [KEY_BITS-1:0] k,
                                               input logic [KEY_BITS-1:0] last);
    logic [KEY_BITS-1:0] d;
    logic [LVL_W-1:0]    l;
    d = k ^ last;
    l = '0;
    for (int j = 1; j < int'(LEVELS); j++) begin
      if ((d >> (j * DIGIT_BITS)) != '0) l = LVL_W'(j);
    end
    return l;
  endfunction

  function automatic logic [DIGIT_BITS-1:0] bkt_of(input logic [KEY_BITS-1:0] k,
                                                   input logic [LVL_W-1:0] l);
    logic [KEY_BITS-1:0] s;
    s = k >> (int'(l) * DIGIT_BITS);
    return DIGIT_BITS'(s);
  endfunction

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [KEY_IN_W-1:0]   key_q, key_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [ID_W-1:0]       rid_q, rid_d;
  logic                  empty_q, empty_d;
  logic                  bad_q, bad_d;
  logic [KEY_BITS-1:0]   last_q, last_d;
  logic [CNT_W-1:0]      held_q, held_d;
  logic [CNT_W-1:0]      fill_q [LEVELS];
  logic [CNT_W-1:0]      fill_d [LEVELS];
  logic [CLR_W-1:0]      clr_q, clr_d;
  logic [LVL_W-1:0]      lev_q, lev_d;
  logic [DIGIT_BITS-1:0] bkt_q, bkt_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic [IDX_W-1:0]      chk_q, chk_d;
  logic                  pv_q, pv_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      best_q, best_d;
  logic [KEY_BITS-1:0]   bestkey_q, bestkey_d;
  logic [BA_W-1:0]       ba1_q, ba1_d;
  logic [BA_W-1:0]       ba2_q, ba2_d;
  logic                  need_b2_q, need_b2_d;
  logic                  redist_q, redist_d;
  logic                  rfirst_q, rfirst_d;

  logic                  accept;
  logic                  id_ok;
  logic [IDX_W-1:0]      id_idx;
  logic [KEY_BITS-1:0]   kval;
  logic                  rec_present;
  logic [KEY_BITS-1:0]   rec_key;
  logic [LVL_W-1:0]      rec_lev;
  logic [DIGIT_BITS-1:0] rec_bkt;
  logic                  rec_match;
  logic                  scan_hit;
  logic                  scan_better;
  logic                  scan_last;
  logic                  clr_last;
  logic [KEY_BITS-1:0]   place_key;
  logic [LVL_W-1:0]      new_lev;
  logic [DIGIT_BITS-1:0] new_bkt;
  logic [LVL_W-1:0]      lsel;
  logic                  lany;
  logic                  finc, fdec;
  logic [LVL_W-1:0]      lvl_inc, lvl_dec;
  logic [SUM_W-1:0]      fill_sum;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign id_ok       = 32'(id_q) < MAX_ITEMS;
  assign id_idx      = IDX_W'(id_q);
  assign kval        = KEY_BITS'(key_q);
  assign rec_present = ir_rdata_i[REC_W-1];
  assign rec_key     = ir_rdata_i[REC_W-2 -: KEY_BITS];
  assign rec_lev     = ir_rdata_i[BA_W-1 -: LVL_W];
  assign rec_bkt     = ir_rdata_i[DIGIT_BITS-1:0];
  assign rec_match   = rec_present && (rec_lev == lev_q) && (rec_bkt == bkt_q);
  assign scan_hit    = pv_q && rec_match;
  assign scan_better = scan_hit && (!found_q || (rec_key < bestkey_q));
  assign scan_last   = scan_q == IDX_W'(MAX_ITEMS - 1);
  assign clr_last    = clr_q == CLR_W'(CLR_N - 1);
  assign place_key   = (state_q == ST_RCHK) ? rec_key : kval;
  assign new_lev     = lvl_of(place_key, last_q);
  assign new_bkt     = bkt_of(place_key, new_lev);

  always_comb begin
    lsel = '0;
    lany = 1'b0;
    for (int l = int'(LEVELS) - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        lsel = LVL_W'(l);
        lany = 1'b1;
      end
    end
  end

  always_comb begin
    fill_sum = '0;
    for (int l = 0; l < int'(LEVELS); l++) begin
      fill_sum = fill_sum + SUM_W'(fill_q[l]);
    end
  end

  always_comb begin
    for (int l = 0; l < int'(LEVELS); l++) begin
      fill_d[l] = fill_q[l]
                + CNT_W'(finc && (lvl_inc == LVL_W'(l)))
                - CNT_W'(fdec && (lvl_dec == LVL_W'(l)));
    end
  end

  assign ir_raddr_o = (state_q == ST_FETCH) ? id_idx : scan_q;
  always_comb begin
    unique case (state_q)
      ST_BRD:   br_raddr_o = {lev_q, bkt_q};
      ST_B2_RD: br_raddr_o = ba2_q;
      default:  br_raddr_o = ba1_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            OP_INSERT, OP_DECREASE: state_d = ST_FETCH;
            OP_EXTRACT:             state_d = ST_LVL;
            default:                state_d = ST_DONE;
          endcase
        end
      end
      ST_FETCH: state_d = ST_CHECK;
      ST_CHECK: begin
        if (op_q == OP_INSERT) begin
          state_d = (!id_ok || rec_present) ? ST_DONE : ST_B2_RD;
        end else begin
          state_d = (!id_ok || !rec_present) ? ST_DONE : ST_B1_RD;
        end
      end
      ST_LVL:   state_d = lany ? ST_BRD : ST_DONE;
      ST_BRD:   state_d = ST_BCHK;
      ST_BCHK: begin
        if (br_rdata_i == '0 && bkt_q != '1) state_d = ST_BRD;
        else state_d = ST_SCAN;
      end
      ST_SCAN:     if (scan_last) state_d = ST_SCAN_END;
      ST_SCAN_END: state_d = (found_q || scan_hit) ? ST_TAKE : ST_DONE;
      ST_TAKE:     state_d = ST_B1_RD;
      ST_B1_RD:    state_d = ST_B1_WR;
      ST_B1_WR: begin
        if (need_b2_q) state_d = ST_B2_RD;
        else state_d = redist_q ? ST_RNEXT : ST_DONE;
      end
      ST_B2_RD: state_d = ST_B2_WR;
      ST_B2_WR: state_d = redist_q ? ST_RNEXT : ST_DONE;
      ST_RNEXT: state_d = (!rfirst_q && scan_last) ? ST_DONE : ST_RRD;
      ST_RRD:   state_d = ST_RCHK;
      ST_RCHK:  state_d = rec_match ? ST_B1_RD : ST_RNEXT;
      ST_DONE:  if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d = op_q;       key_d = key_q;         id_d = id_q;
    rid_d = rid_q;     empty_d = empty_q;     bad_d = bad_q;
    last_d = last_q;   held_d = held_q;       clr_d = clr_q;
    lev_d = lev_q;     bkt_d = bkt_q;         scan_d = scan_q;
    chk_d = chk_q;     pv_d = pv_q;           found_d = found_q;
    best_d = best_q;   bestkey_d = bestkey_q;
    ba1_d = ba1_q;     ba2_d = ba2_q;         need_b2_d = need_b2_q;
    redist_d = redist_q;                      rfirst_d = rfirst_q;
    ir_we_o = 1'b0;    ir_waddr_o = scan_q;   ir_wdata_o = '0;
    br_we_o = 1'b0;    br_waddr_o = ba1_q;    br_wdata_o = '0;
    finc = 1'b0;       fdec = 1'b0;
    lvl_inc = new_lev; lvl_dec = lev_q;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ir_we_o    = 32'(clr_q) < MAX_ITEMS;
        ir_waddr_o = clr_q[IDX_W-1:0];
        br_we_o    = 32'(clr_q) < BDEPTH;
        br_waddr_o = clr_q[BA_W-1:0];
        clr_d      = clr_q + CLR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_d    = operation_i;
          key_d   = key_i;
          id_d    = item_id_i;
          rid_d   = '0;
          empty_d = 1'b0;
          bad_d   = 1'b0;
        end
      end
      ST_CHECK: begin
        ir_waddr_o = id_idx;
        ir_wdata_o = {1'b1, kval, new_lev, new_bkt};
        ba1_d      = {rec_lev, rec_bkt};
        ba2_d      = {new_lev, new_bkt};
        redist_d   = 1'b0;
        need_b2_d  = 1'b1;
        lvl_dec    = rec_lev;
        if (op_q == OP_INSERT) begin
          if (!id_ok || rec_present) begin
            bad_d = 1'b1;
          end else begin
            ir_we_o = 1'b1;
            finc    = 1'b1;
            held_d  = held_q + CNT_W'(1);
          end
        end else begin
          if (!id_ok || !rec_present) begin
            bad_d = 1'b1;
          end else begin
            ir_we_o = 1'b1;
            finc    = 1'b1;
            fdec    = 1'b1;
          end
        end
      end
      ST_LVL: begin
        lev_d = lsel;
        bkt_d = '0;
        if (!lany) empty_d = 1'b1;
      end
      ST_BCHK: begin
        if (br_rdata_i == '0 && bkt_q != '1) bkt_d = bkt_q + DIGIT_BITS'(1);
        scan_d  = '0;
        pv_d    = 1'b0;
        found_d = 1'b0;
      end
      ST_SCAN, ST_SCAN_END: begin
        chk_d = scan_q;
        pv_d  = 1'b1;
        if (state_q == ST_SCAN && !scan_last) scan_d = scan_q + IDX_W'(1);
        if (scan_hit) found_d = 1'b1;
        if (scan_better) begin
          best_d    = chk_q;
          bestkey_d = rec_key;
        end
        if (state_q == ST_SCAN_END && !(found_q || scan_hit)) empty_d = 1'b1;
      end
      ST_TAKE: begin
        ir_we_o    = 1'b1;
        ir_waddr_o = best_q;
        last_d     = bestkey_q;
        held_d     = held_q - CNT_W'(1);
        fdec       = 1'b1;
        rid_d      = ID_W'(best_q);
        ba1_d      = {lev_q, bkt_q};
        need_b2_d  = 1'b0;
        redist_d   = lev_q != '0;
        rfirst_d   = 1'b1;
      end
      ST_B1_WR: begin
        br_we_o    = 1'b1;
        br_waddr_o = ba1_q;
        br_wdata_o = br_rdata_i - CNT_W'(1);
      end
      ST_B2_WR: begin
        br_we_o    = 1'b1;
        br_waddr_o = ba2_q;
        br_wdata_o = br_rdata_i + CNT_W'(1);
      end
      ST_RNEXT: begin
        if (rfirst_q) begin
          scan_d   = '0;
          rfirst_d = 1'b0;
        end else if (!scan_last) begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_RCHK: begin
        if (rec_match) begin
          ir_we_o    = 1'b1;
          ir_waddr_o = scan_q;
          ir_wdata_o = {1'b1, rec_key, new_lev, new_bkt};
          finc       = 1'b1;
          fdec       = 1'b1;
          ba1_d      = {lev_q, bkt_q};
          ba2_d      = {new_lev, new_bkt};
          need_b2_d  = 1'b1;
        end
      end
      ST_DONE: res_valid_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      last_q   <= '0;
      held_q   <= '0;
      for (int l = 0; l < int'(LEVELS); l++) fill_q[l] <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      last_q   <= last_d;
      held_q   <= held_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    id_q      <= id_d;
    rid_q     <= rid_d;
    empty_q   <= empty_d;
    bad_q     <= bad_d;
    lev_q     <= lev_d;
    bkt_q     <= bkt_d;
    scan_q    <= scan_d;
    chk_q     <= chk_d;
    pv_q      <= pv_d;
    found_q   <= found_d;
    best_q    <= best_d;
    bestkey_q <= bestkey_d;
    ba1_q     <= ba1_d;
    ba2_q     <= ba2_d;
    need_b2_q <= need_b2_d;
    redist_q  <= redist_d;
    rfirst_q  <= rfirst_d;
  end

  assign in_stall_o        = state_q != ST_IDLE;
  assign res_o.result_id   = rid_q;
  assign res_o.queue_empty = empty_q;
  assign res_o.bad_request = bad_q;
  assign res_o.item_total  = TOTAL_W'(held_q);

  `MLBPQ_CHECK(a_fill_matches_held, fill_sum == SUM_W'(held_q), "level fill sum differs from held count")
  `MLBPQ_CHECK_IMP(a_flags_exclusive, res_valid_o, !(res_o.queue_empty && res_o.bad_request), "empty and bad both set")
  `MLBPQ_CHECK_IMP(a_empty_no_id, res_valid_o && res_o.queue_empty, res_o.result_id == '0, "empty result carries an id")

endmodule

// ===== hdl/multilevel_bucket_priority_queue.sv =====
// Insert and decrease fetch and check the item record, then update the bucket counts.
// Extract takes the first non-empty bucket's minimum, then re-buckets a level > 0 one.
// One transaction at a time; a finished result waits in the output register while
// the next transaction is taken.
// Reset: after rst_ni a clearing pass of max(MAX_ITEMS, 2^(level bits + DIGIT_BITS))
// cycles zeroes both memories with in_stall_o high.
module multilevel_bucket_priority_queue
  import mlbpq_pkg::*;
#(
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF,
  parameter int unsigned MAX_ITEMS  = MAX_ITEMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic [ID_W-1:0]     item_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ID_W-1:0]     result_id_o,
  output logic                queue_empty_o,
  output logic                bad_request_o,
  output logic [TOTAL_W-1:0]  item_total_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned REC_W = 1 + KEY_BITS + LVL_W + DIGIT_BITS;
  localparam int unsigned BA_W  = LVL_W + DIGIT_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic             ir_we;
  logic [IDX_W-1:0] ir_waddr, ir_raddr;
  logic [REC_W-1:0] ir_wdata, ir_rdata;
  logic             br_we;
  logic [BA_W-1:0]  br_waddr, br_raddr;
  logic [CNT_W-1:0] br_wdata, br_rdata;
  logic             out_free;
  logic             res_valid;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  mlbpq_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ITEMS),
    .AW    (IDX_W)
  ) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (ir_we),
    .waddr_i (ir_waddr),
    .wdata_i (ir_wdata),
    .raddr_i (ir_raddr),
    .rdata_o (ir_rdata)
  );

  mlbpq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (1 << BA_W),
    .AW    (BA_W)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (br_we),
    .waddr_i (br_waddr),
    .wdata_i (br_wdata),
    .raddr_i (br_raddr),
    .rdata_o (br_rdata)
  );

  mlbpq_core #(
    .LEVELS     (LEVELS),
    .KEY_BITS   (KEY_BITS),
    .DIGIT_BITS (DIGIT_BITS),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .item_id_i   (item_id_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ir_we_o     (ir_we),
    .ir_waddr_o  (ir_waddr),
    .ir_wdata_o  (ir_wdata),
    .ir_raddr_o  (ir_raddr),
    .ir_rdata_i  (ir_rdata),
    .br_we_o     (br_we),
    .br_waddr_o  (br_waddr),
    .br_wdata_o  (br_wdata),
    .br_raddr_o  (br_raddr),
    .br_rdata_i  (br_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_id_o   = out_q.result_id;
  assign queue_empty_o = out_q.queue_empty;
  assign bad_request_o = out_q.bad_request;
  assign item_total_o  = out_q.item_total;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the multilevel bucket priority queue: runs directed and random
// insert, extract-min and decrease-key transactions, and checks each result against a
// behavioral predictor of the queue. Depends on mlbpq_pkg and the queue RTL.
module tb_top;
  import mlbpq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned NUM_IDS     = 1024;
  localparam int unsigned BKTS        = 256;
  localparam int unsigned RANDOM_OPS  = 750;
  localparam int unsigned CYCLE_LIMIT = 40000000;
  localparam int unsigned DRAIN_WAIT  = 8000;

  class mlbpq_scoreboard;
    logic [15:0]  key_mem [NUM_IDS];
    bit           held    [NUM_IDS];
    bit           lvl     [NUM_IDS];
    logic [7:0]   bkt     [NUM_IDS];
    int unsigned  bucket_cnt [2*BKTS];
    int unsigned  level_cnt  [2];
    logic [15:0]  last_key;
    int unsigned  held_cnt;
    res_t         expected_q [$];
    int unsigned  errors;

    function void init();
      for (int i = 0; i < NUM_IDS; i++) held[i] = 0;
      for (int i = 0; i < 2*BKTS; i++) bucket_cnt[i] = 0;
      level_cnt[0] = 0;
      level_cnt[1] = 0;
      last_key = '0;
      held_cnt = 0;
      errors = 0;
    endfunction

    function void place(int id);
      logic [15:0] diff;
      diff = key_mem[id] ^ last_key;
      lvl[id] = (diff[15:8] != 0);
      bkt[id] = lvl[id] ? key_mem[id][15:8] : key_mem[id][7:0];
      bucket_cnt[lvl[id]*BKTS + bkt[id]]++;
      level_cnt[lvl[id]]++;
    endfunction

    function void unplace(int id);
      bucket_cnt[lvl[id]*BKTS + bkt[id]]--;
      level_cnt[lvl[id]]--;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [15:0] key, logic [ID_W-1:0] id);
      res_t exp_res;
      int lv, b, best;
      bit found;
      exp_res = '0;
      if (op == OP_INSERT) begin
        if (held[id]) exp_res.bad_request = 1;
        else begin
          key_mem[id] = key;
          held[id] = 1;
          place(id);
          held_cnt++;
        end
      end else if (op == OP_DECREASE) begin
        if (!held[id]) exp_res.bad_request = 1;
        else begin
          unplace(id);
          key_mem[id] = key;
          place(id);
        end
      end else if (op == OP_EXTRACT) begin
        lv = 0;
        while (lv < 2 && level_cnt[lv] == 0) lv++;
        if (lv >= 2) exp_res.queue_empty = 1;
        else begin
          b = 0;
          while (b < BKTS-1 && bucket_cnt[lv*BKTS + b] == 0) b++;
          found = 0;
          best = 0;
          for (int i = 0; i < NUM_IDS; i++)
            if (held[i] && lvl[i] == lv && bkt[i] == b)
              if (!found || key_mem[i] < key_mem[best]) begin
                best = i;
                found = 1;
              end
          if (!found) exp_res.queue_empty = 1;
          else begin
            last_key = key_mem[best];
            unplace(best);
            held[best] = 0;
            held_cnt--;
            exp_res.result_id = ID_W'(best);
            if (lv != 0)
              for (int i = 0; i < NUM_IDS; i++)
                if (held[i] && lvl[i] == lv && bkt[i] == b) begin
                  unplace(i);
                  place(i);
                end
          end
        end
      end
      exp_res.item_total = held_cnt[TOTAL_W-1:0];
      expected_q.push_back(exp_res);
    endfunction

    function void check_result(res_t got);
      res_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.result_id !== exp_res.result_id) begin
        $display("%0t: result_id expected %0d actual %0d", $time, exp_res.result_id,
                 got.result_id);
        errors++;
      end
      if (got.queue_empty !== exp_res.queue_empty) begin
        $display("%0t: queue_empty expected %0b actual %0b", $time, exp_res.queue_empty,
                 got.queue_empty);
        errors++;
      end
      if (got.bad_request !== exp_res.bad_request) begin
        $display("%0t: bad_request expected %0b actual %0b", $time, exp_res.bad_request,
                 got.bad_request);
        errors++;
      end
      if (got.item_total !== exp_res.item_total) begin
        $display("%0t: item_total expected %0d actual %0d", $time, exp_res.item_total,
                 got.item_total);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = '0;
  logic [KEY_IN_W-1:0] key = '0;
  logic [ID_W-1:0]     item_id = '0;
  logic                out_valid;
  logic                out_stall = 0;
  logic [ID_W-1:0]     result_id;
  logic                queue_empty;
  logic                bad_request;
  logic [TOTAL_W-1:0]  item_total;
  int unsigned         cycles = 0;
  int unsigned         stall_mode = 0;
  mlbpq_scoreboard     sb;

  multilevel_bucket_priority_queue i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .key_i         (key),
    .item_id_i     (item_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_id_o   (result_id),
    .queue_empty_o (queue_empty),
    .bad_request_o (bad_request),
    .item_total_o  (item_total)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{result_id, queue_empty, bad_request, item_total});

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send(logic [OP_W-1:0] op, logic [15:0] k, logic [ID_W-1:0] id);
    @(negedge clk);
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    item_id   <= id;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, k, id);
  endtask

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  function automatic logic [ID_W-1:0] pick_held_id();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, NUM_IDS-1));
    if (sb.held_cnt == 0) return id;
    for (int t = 0; t < 64; t++) begin
      if (sb.held[id]) return id;
      id = ID_W'($urandom_range(0, NUM_IDS-1));
    end
    return id;
  endfunction

  task automatic random_op();
    int sel;
    logic [15:0] k;
    logic [ID_W-1:0] id;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) k = 16'($urandom_range(0, 16'hFFFF));
    else k = sb.last_key ^ 16'($urandom_range(0, 255));
    if (sel < 45) begin
      id = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 63))
                                       : 10'($urandom_range(0, NUM_IDS-1));
      send(OP_INSERT, k, id);
    end else if (sel < 80) begin
      send(OP_EXTRACT, 16'($urandom_range(0, 16'hFFFF)), ID_W'($urandom_range(0, NUM_IDS-1)));
    end else if (sel < 95) begin
      id = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, NUM_IDS-1)) : pick_held_id();
      send(OP_DECREASE, k, id);
    end else begin
      send(OP_UNUSED, 16'($urandom_range(0, 16'hFFFF)), ID_W'($urandom_range(0, NUM_IDS-1)));
    end
  endtask

  initial begin
    int burst;
    int waited;
    sb = new();
    sb.init();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_INSERT, 16'h0000, 10'd0);
    send(OP_INSERT, 16'hFFFF, 10'h3FF);
    send(OP_INSERT, 16'h1234, 10'h3FF);
    send(OP_DECREASE, 16'h0010, 10'd5);
    send(OP_UNUSED, 16'hFFFF, 10'h3FF);
    send(OP_INSERT, 16'h0101, 10'd20);
    send(OP_INSERT, 16'h0101, 10'd10);
    send(OP_INSERT, 16'h0180, 10'd30);
    send(OP_EXTRACT, 16'hFFFF, 10'h3FF);
    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_INSERT, 16'h0000, 10'd40);
    send(OP_DECREASE, 16'hFF00, 10'd20);
    send(OP_DECREASE, 16'h0100, 10'd30);
    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_EXTRACT, 16'h0000, 10'd0);
    send(OP_EXTRACT, 16'h0000, 10'd0);

    for (int n = 0; n < RANDOM_OPS; ) begin
      burst = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
      for (int j = 0; j < burst && n < RANDOM_OPS; j++, n++) random_op();
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
    end
    pause(1);

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
